// ===== src/tlf_pkg.sv =====
// Shared types, constants and character helpers for the traffic log formatter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tlf_pkg;

   localparam int unsigned LINE_BYTES    = 16;
   localparam int unsigned LINE_IDX_W    = $clog2(LINE_BYTES);
   localparam int unsigned STEP_W        = LINE_IDX_W;
   localparam int unsigned OFFSET_W      = 32;
   localparam int unsigned SPLIT_W       = 16;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned QUEUE_DEPTH_D = 4;

   typedef enum logic [2:0] {
      MODE_NONE  = 3'd0,
      MODE_RAW   = 3'd1,
      MODE_STRIP = 3'd2,
      MODE_HEX   = 3'd3,
      MODE_ESC   = 3'd4
   } log_mode_type;

   typedef enum logic {
      CSR_LOG_MODE     = 1'b0,
      CSR_SPLIT_LENGTH = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_ARROW,
      SEQ_OFFSET,
      SEQ_OFF_SP,
      SEQ_BODY,
      SEQ_GAP,
      SEQ_ASC_HEAD,
      SEQ_ASC_BODY,
      SEQ_ASC_TAIL,
      SEQ_LINE_NL,
      SEQ_END_NL
   } seq_state_type;

   // One classified input transaction, as handed from front to back.
   typedef struct packed {
      log_mode_type            mode;
      logic [7:0]              data_byte;
      logic                    outbound;
      logic                    prefix;      // buffer start: arrow (and offset) first
      logic                    has_byte;
      logic                    extra_gap;   // hex: byte 8 of a line
      logic                    ascii_col;   // hex: ASCII column follows
      logic                    new_line;    // hex: line full, new offset line
      logic                    split_line;  // escaped: split after this byte
      logic                    close;       // final newline
      logic [LINE_IDX_W-1:0]   line_idx;    // hex: slot of this byte in the line
      logic [OFFSET_W-1:0]     offset;      // hex: offset for the new line
   } item_cmd_type;

   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_LC_N   = 8'h6E;
   localparam logic [7:0] CH_LC_R   = 8'h72;
   localparam logic [7:0] CH_LC_T   = 8'h74;

   localparam logic [7:0] BYTE_TAB  = 8'd9;
   localparam logic [7:0] BYTE_LF   = 8'd10;
   localparam logic [7:0] BYTE_CR   = 8'd13;
   localparam logic [7:0] BYTE_BSL  = 8'd92;
   localparam logic [7:0] BYTE_SP   = 8'd32;
   localparam logic [7:0] BYTE_TILD = 8'd126;
   localparam logic [7:0] BYTE_DEL  = 8'd127;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
   endfunction

   function automatic logic printable(input logic [7:0] b);
      printable = (b >= BYTE_SP) && (b <= BYTE_TILD);
   endfunction

   function automatic logic esc_special(input logic [7:0] b);
      esc_special = (b == BYTE_BSL) || (b == BYTE_TAB) || (b == BYTE_LF) || (b == BYTE_CR);
   endfunction

   function automatic logic [1:0] esc_len(input logic [7:0] b);
      if (esc_special(b)) begin
         esc_len = 2'd2;
      end else if (b >= BYTE_SP && b <= BYTE_DEL) begin
         esc_len = 2'd1;
      end else begin
         esc_len = 2'd3;
      end
   endfunction

   function automatic logic [7:0] esc_char(input logic [7:0] b, input logic [1:0] idx);
      logic plain;
      plain = !esc_special(b) && (b >= BYTE_SP) && (b <= BYTE_DEL);
      if (idx == 2'd0) begin
         esc_char = plain ? b : CH_BSLASH;
      end else if (idx == 2'd1) begin
         if (b == BYTE_BSL) begin
            esc_char = CH_BSLASH;
         end else if (b == BYTE_TAB) begin
            esc_char = CH_LC_T;
         end else if (b == BYTE_LF) begin
            esc_char = CH_LC_N;
         end else if (b == BYTE_CR) begin
            esc_char = CH_LC_R;
         end else begin
            esc_char = hex_char(b[7:4]);
         end
      end else begin
         esc_char = hex_char(b[3:0]);
      end
   endfunction

endpackage

`default_nettype wire

// ===== src/tlf_front.sv =====
// Front end: configuration registers, buffer state and classification of
// each input transaction into a command. Depends on tlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlf_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [7:0]                   req_data_byte,
   input  wire logic                         req_byte_valid,
   input  wire logic                         req_outbound,
   input  wire logic                         req_buffer_end,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [tlf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                         q_full,
   output logic                              q_push,
   output tlf_pkg::item_cmd_type             q_cmd
);

   tlf_pkg::log_mode_type                  log_mode_ff, log_mode_in;
   logic [tlf_pkg::SPLIT_W-1:0]            split_len_ff, split_len_in;
   logic                                   at_start_ff, at_start_in;
   logic [tlf_pkg::OFFSET_W-1:0]           byte_offset_ff, byte_offset_in;
   logic [tlf_pkg::SPLIT_W-1:0]            split_cnt_ff, split_cnt_in;

   logic                                   mode_active;
   logic                                   is_hex;
   logic                                   is_esc;
   logic                                   end_eff;
   logic [tlf_pkg::OFFSET_W-1:0]           base_off;
   logic [tlf_pkg::OFFSET_W-1:0]           pos;
   logic [tlf_pkg::SPLIT_W-1:0]            base_split;
   logic [tlf_pkg::SPLIT_W-1:0]            split_next;
   logic [tlf_pkg::LINE_IDX_W-1:0]         k;
   logic                                   accept;

   assign req_stall = q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      mode_active = (log_mode_ff == tlf_pkg::MODE_RAW) || (log_mode_ff == tlf_pkg::MODE_STRIP)
                 || (log_mode_ff == tlf_pkg::MODE_HEX) || (log_mode_ff == tlf_pkg::MODE_ESC);
      is_hex      = (log_mode_ff == tlf_pkg::MODE_HEX);
      is_esc      = (log_mode_ff == tlf_pkg::MODE_ESC);
      end_eff     = !req_byte_valid || req_buffer_end;
      base_off    = at_start_ff ? '0 : byte_offset_ff;
      base_split  = at_start_ff ? '0 : split_cnt_ff;
      pos         = base_off + tlf_pkg::OFFSET_W'(1);
      split_next  = base_split + tlf_pkg::SPLIT_W'(1);
      k           = pos[tlf_pkg::LINE_IDX_W-1:0];

      q_push           = accept && mode_active;
      q_cmd.mode       = log_mode_ff;
      q_cmd.data_byte  = req_data_byte;
      q_cmd.outbound   = req_outbound;
      q_cmd.prefix     = at_start_ff;
      q_cmd.has_byte   = req_byte_valid;
      q_cmd.extra_gap  = is_hex && req_byte_valid
                      && (k == tlf_pkg::LINE_IDX_W'(tlf_pkg::LINE_BYTES / 2));
      q_cmd.ascii_col  = is_hex && req_byte_valid && ((k == '0) || req_buffer_end);
      q_cmd.new_line   = is_hex && req_byte_valid && (k == '0);
      q_cmd.split_line = is_esc && req_byte_valid && (split_next == split_len_ff);
      q_cmd.close      = end_eff;
      q_cmd.line_idx   = base_off[tlf_pkg::LINE_IDX_W-1:0];
      q_cmd.offset     = pos;
   end

   always_comb begin
      at_start_in    = at_start_ff;
      byte_offset_in = byte_offset_ff;
      split_cnt_in   = split_cnt_ff;
      if (q_push) begin
         at_start_in    = end_eff;
         byte_offset_in = (req_byte_valid && (is_hex || is_esc)) ? pos : base_off;
         if (req_byte_valid && is_esc) begin
            split_cnt_in = q_cmd.split_line ? '0 : split_next;
         end else begin
            split_cnt_in = base_split;
         end
      end
   end

   always_comb begin
      log_mode_in  = log_mode_ff;
      split_len_in = split_len_ff;
      if (csr_valid && csr_ready) begin
         unique case (tlf_pkg::csr_index_type'(csr_index))
            tlf_pkg::CSR_LOG_MODE:     log_mode_in  = tlf_pkg::log_mode_type'(csr_wdata[2:0]);
            tlf_pkg::CSR_SPLIT_LENGTH: split_len_in = csr_wdata[tlf_pkg::SPLIT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_mode_ff    <= tlf_pkg::MODE_NONE;
         split_len_ff   <= tlf_pkg::SPLIT_W'(1);
         at_start_ff    <= 1'b1;
         byte_offset_ff <= '0;
         split_cnt_ff   <= '0;
      end else begin
         log_mode_ff    <= log_mode_in;
         split_len_ff   <= split_len_in;
         at_start_ff    <= at_start_in;
         byte_offset_ff <= byte_offset_in;
         split_cnt_ff   <= split_cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/tlf_queue.sv =====
// Short command queue between the front and back ends.
// Depends on tlf_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module tlf_queue #(
   parameter int unsigned DEPTH = tlf_pkg::QUEUE_DEPTH_D
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire tlf_pkg::item_cmd_type      push_cmd,
   input  wire logic                       pop,
   output tlf_pkg::item_cmd_type           head_cmd,
   output logic                            full,
   output logic                            empty,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   tlf_pkg::item_cmd_type   slots_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign head_cmd = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/tlf_back.sv =====
// Back end: character sequencer that expands one command into log text,
// the hex line store and the output register. Depends on tlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire tlf_pkg::item_cmd_type q_head,
   output logic                    q_pop,
   output logic                    back_idle,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_log_char,
   output logic                    rsp_char_last
);

   tlf_pkg::seq_state_type          state_ff, state_in;
   tlf_pkg::item_cmd_type           cmd_ff, cmd_in;
   logic [tlf_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                            in_line_ff, in_line_in;
   logic [7:0]                      line_store_ff [tlf_pkg::LINE_BYTES];
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      rsp_char_ff, rsp_char_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            adv;
   logic                            seg_last;
   logic                            done;
   logic                            load;
   tlf_pkg::seq_state_type          follow;
   tlf_pkg::seq_state_type          first_state;
   tlf_pkg::seq_state_type          after_line;
   tlf_pkg::seq_state_type          after_prefix;
   tlf_pkg::seq_state_type          after_asc;
   tlf_pkg::seq_state_type          after_gap;
   logic [1:0]                      body_len;
   logic [7:0]                      body_char;
   logic [7:0]                      cur_char;
   logic [tlf_pkg::OFFSET_W-1:0]    off_val;
   logic [3:0]                      off_nib;
   logic [7:0]                      asc_byte;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_log_char  = rsp_char_ff;
   assign rsp_char_last = rsp_last_ff;
   assign back_idle     = (state_ff == tlf_pkg::SEQ_IDLE);
   // output register is free this cycle
   assign adv           = !rsp_valid_ff || !rsp_stall;

   // body character and length of the current command
   always_comb begin
      body_len  = 2'd1;
      body_char = cmd_ff.data_byte;
      unique case (cmd_ff.mode)
         tlf_pkg::MODE_RAW: begin
            body_len  = 2'd1;
            body_char = cmd_ff.data_byte;
         end
         tlf_pkg::MODE_STRIP: begin
            body_len  = 2'd1;
            body_char = tlf_pkg::printable(cmd_ff.data_byte) ? cmd_ff.data_byte
                                                             : tlf_pkg::CH_DOT;
         end
         tlf_pkg::MODE_HEX: begin
            body_len = 2'd3;
            if (step_ff == tlf_pkg::STEP_W'(0)) begin
               body_char = tlf_pkg::hex_char(cmd_ff.data_byte[7:4]);
            end else if (step_ff == tlf_pkg::STEP_W'(1)) begin
               body_char = tlf_pkg::hex_char(cmd_ff.data_byte[3:0]);
            end else begin
               body_char = tlf_pkg::CH_SPACE;
            end
         end
         tlf_pkg::MODE_ESC: begin
            body_len  = tlf_pkg::esc_len(cmd_ff.data_byte);
            body_char = tlf_pkg::esc_char(cmd_ff.data_byte, step_ff[1:0]);
         end
         default: begin
            body_len  = 2'd1;
            body_char = cmd_ff.data_byte;
         end
      endcase
   end

   // segment decode: last character of the segment and the segment after it
   always_comb begin
      after_line   = cmd_ff.close ? tlf_pkg::SEQ_END_NL : tlf_pkg::SEQ_IDLE;
      after_prefix = cmd_ff.has_byte ? tlf_pkg::SEQ_BODY : tlf_pkg::SEQ_END_NL;
      after_asc    = cmd_ff.new_line ? tlf_pkg::SEQ_LINE_NL : after_line;
      after_gap    = cmd_ff.ascii_col ? tlf_pkg::SEQ_ASC_HEAD : after_asc;
      first_state  = q_head.prefix ? tlf_pkg::SEQ_ARROW
                   : (q_head.has_byte ? tlf_pkg::SEQ_BODY : tlf_pkg::SEQ_END_NL);
      seg_last     = 1'b0;
      follow       = tlf_pkg::SEQ_IDLE;
      unique case (state_ff)
         tlf_pkg::SEQ_IDLE: begin
            seg_last = 1'b0;
            follow   = tlf_pkg::SEQ_IDLE;
         end
         tlf_pkg::SEQ_ARROW: begin
            seg_last = (step_ff == tlf_pkg::STEP_W'(3));
            if (cmd_ff.mode == tlf_pkg::MODE_HEX) begin
               follow = tlf_pkg::SEQ_OFFSET;
            end else begin
               follow = in_line_ff ? after_line : after_prefix;
            end
         end
         tlf_pkg::SEQ_OFFSET: begin
            seg_last = (step_ff == tlf_pkg::STEP_W'(7));
            follow   = tlf_pkg::SEQ_OFF_SP;
         end
         tlf_pkg::SEQ_OFF_SP: begin
            seg_last = (step_ff == tlf_pkg::STEP_W'(1));
            follow   = in_line_ff ? after_line : after_prefix;
         end
         tlf_pkg::SEQ_BODY: begin
            seg_last = (step_ff == tlf_pkg::STEP_W'(body_len - 2'd1));
            if (cmd_ff.mode == tlf_pkg::MODE_HEX) begin
               follow = cmd_ff.extra_gap ? tlf_pkg::SEQ_GAP : after_gap;
            end else if (cmd_ff.mode == tlf_pkg::MODE_ESC) begin
               follow = cmd_ff.split_line ? tlf_pkg::SEQ_LINE_NL : after_line;
            end else begin
               follow = after_line;
            end
         end
         tlf_pkg::SEQ_GAP: begin
            seg_last = 1'b1;
            follow   = after_gap;
         end
         tlf_pkg::SEQ_ASC_HEAD: begin
            seg_last = (step_ff == tlf_pkg::STEP_W'(2));
            follow   = tlf_pkg::SEQ_ASC_BODY;
         end
         tlf_pkg::SEQ_ASC_BODY: begin
            // the column runs up to and including this command's byte
            seg_last = (step_ff == cmd_ff.line_idx);
            follow   = tlf_pkg::SEQ_ASC_TAIL;
         end
         tlf_pkg::SEQ_ASC_TAIL: begin
            seg_last = 1'b1;
            follow   = after_asc;
         end
         tlf_pkg::SEQ_LINE_NL: begin
            seg_last = 1'b1;
            follow   = tlf_pkg::SEQ_ARROW;
         end
         tlf_pkg::SEQ_END_NL: begin
            seg_last = 1'b1;
            follow   = tlf_pkg::SEQ_IDLE;
         end
      endcase
      done = (state_ff != tlf_pkg::SEQ_IDLE) && seg_last && (follow == tlf_pkg::SEQ_IDLE);
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      in_line_in = in_line_ff;
      cmd_in     = cmd_ff;
      if (load) begin
         state_in   = first_state;
         step_in    = '0;
         in_line_in = 1'b0;
         cmd_in     = q_head;
      end else if (state_ff != tlf_pkg::SEQ_IDLE && adv) begin
         if (seg_last) begin
            state_in = follow;
            step_in  = '0;
            if (state_ff == tlf_pkg::SEQ_LINE_NL) begin
               in_line_in = 1'b1;
            end
         end else begin
            step_in = step_ff + tlf_pkg::STEP_W'(1);
         end
      end
   end

   // outputs: current character, queue pop, output register
   always_comb begin
      off_val  = in_line_ff ? cmd_ff.offset : '0;
      off_nib  = 4'(off_val >> {~step_ff[2:0], 2'b00});
      asc_byte = line_store_ff[step_ff];
      cur_char = tlf_pkg::CH_SPACE;
      unique case (state_ff)
         tlf_pkg::SEQ_IDLE:     cur_char = tlf_pkg::CH_SPACE;
         tlf_pkg::SEQ_ARROW: begin
            if (step_ff == tlf_pkg::STEP_W'(0)) begin
               cur_char = cmd_ff.outbound ? tlf_pkg::CH_DASH : tlf_pkg::CH_LT;
            end else if (step_ff == tlf_pkg::STEP_W'(1)) begin
               cur_char = tlf_pkg::CH_DASH;
            end else if (step_ff == tlf_pkg::STEP_W'(2)) begin
               cur_char = cmd_ff.outbound ? tlf_pkg::CH_GT : tlf_pkg::CH_DASH;
            end else begin
               cur_char = tlf_pkg::CH_SPACE;
            end
         end
         tlf_pkg::SEQ_OFFSET:   cur_char = tlf_pkg::hex_char(off_nib);
         tlf_pkg::SEQ_OFF_SP:   cur_char = tlf_pkg::CH_SPACE;
         tlf_pkg::SEQ_BODY:     cur_char = body_char;
         tlf_pkg::SEQ_GAP:      cur_char = tlf_pkg::CH_SPACE;
         tlf_pkg::SEQ_ASC_HEAD: begin
            cur_char = (step_ff == tlf_pkg::STEP_W'(2)) ? tlf_pkg::CH_BAR : tlf_pkg::CH_SPACE;
         end
         tlf_pkg::SEQ_ASC_BODY: begin
            cur_char = tlf_pkg::printable(asc_byte) ? asc_byte : tlf_pkg::CH_DOT;
         end
         tlf_pkg::SEQ_ASC_TAIL: cur_char = tlf_pkg::CH_BAR;
         tlf_pkg::SEQ_LINE_NL:  cur_char = tlf_pkg::CH_NL;
         tlf_pkg::SEQ_END_NL:   cur_char = tlf_pkg::CH_NL;
      endcase

      load  = !q_empty && ((state_ff == tlf_pkg::SEQ_IDLE) || (adv && done));
      q_pop = load;

      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (adv) begin
         rsp_valid_in = (state_ff != tlf_pkg::SEQ_IDLE);
         rsp_char_in  = cur_char;
         rsp_last_in  = done;
      end
   end

   always_ff @(posedge clock) begin
      if (load && (q_head.mode == tlf_pkg::MODE_HEX) && q_head.has_byte) begin
         line_store_ff[q_head.line_idx] <= q_head.data_byte;
      end
      cmd_ff      <= cmd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlf_pkg::SEQ_IDLE;
         step_ff      <= '0;
         in_line_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         in_line_ff   <= in_line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/traffic_log_formatter_unit.sv =====
// Top level of the traffic log formatter: front end, command queue, back end.
// Depends on tlf_pkg, tlf_front, tlf_queue and tlf_back.
`timescale 1ns / 1ps
`default_nettype none

// Turns buffer bytes into log text, one character per cycle on the rsp channel
// while rsp_stall is low. Each req transaction (one byte plus direction,
// buffer-end and valid flags) yields 0 to 39 characters; char_last marks the
// final one. The front end accepts one transaction per cycle while the
// QUEUE_DEPTH-entry command queue has room; the back-end character sequencer
// emits 1 character per raw/strip byte, 1 to 3 per escaped byte plus 5 on a
// line split, 3 to 4 per hex byte plus 20 for the ASCII column and 15 for the
// new offset line when a hex line fills, and passes through its idle state to
// take the next command when it had run dry. Mode none drops transactions
// without output. Write log_mode (index 0) and split_length (index 1) only while the block is idle.
module traffic_log_formatter_unit #(
   parameter int unsigned QUEUE_DEPTH = tlf_pkg::QUEUE_DEPTH_D
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic                           req_byte_valid,
   input  wire logic                           req_outbound,
   input  wire logic                           req_buffer_end,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [7:0]                          rsp_log_char,
   output logic                                rsp_char_last,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic                           csr_index,
   input  wire logic [tlf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tlf_pkg::item_cmd_type              q_cmd;
   tlf_pkg::item_cmd_type              q_head;
   logic                               q_push;
   logic                               q_pop;
   logic                               q_full;
   logic                               q_empty;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]   q_count;
   logic                               back_idle;

   tlf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_byte_valid (req_byte_valid),
      .req_outbound   (req_outbound),
      .req_buffer_end (req_buffer_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (q_cmd)
   );

   tlf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head_cmd (q_head),
      .full     (q_full),
      .empty    (q_empty),
      .count    (q_count)
   );

   tlf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .back_idle     (back_idle),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_log_char  (rsp_log_char),
      .rsp_char_last (rsp_char_last)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_back_starts: assert property (@(posedge clock) disable iff (reset)
      (back_idle && !q_empty) |=> !back_idle)
      else $error("back end idle with a pending command");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire
